// ===== hw/rtl/hbp_pkg.sv =====
// Shared types and constants for the Huffman bit packer.
// Holds the item mode codes, the queue entry layout and the sizing constants.
// No dependencies.
package hbp_pkg;

    localparam int NUM_SYMBOLS  = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_W       = 32;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int SYM_IDX_W    = $clog2(NUM_SYMBOLS);
    localparam int LEN_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int PEND_W       = 7;
    localparam int PCNT_W       = 3;
    localparam int ACC_W        = PEND_W + CODE_W;
    localparam int REM_W        = 3;
    localparam int COUNT_W      = 32;
    localparam int ENTRY_W      = LEN_W + CODE_W;

    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [LEN_W-1:0]   clen;
        logic [CODE_W-1:0]  cbits;
        logic [COUNT_W-1:0] count;
    } hbp_entry_t;

endpackage

// ===== hw/rtl/hbp_fifo.sv =====
// Short queue of work entries between the front end and the packer.
// Depends on hbp_pkg for the entry type and the queue depth.
module hbp_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hbp_pkg::hbp_entry_t push_entry,
    input  logic               pop,
    output hbp_pkg::hbp_entry_t head_entry,
    output logic               full,
    output logic               empty
);
    import hbp_pkg::*;

    hbp_entry_t            slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;

    assign full       = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty      = (cnt_reg == '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/hbp_front.sv =====
// Front end: accepts items, owns the code table and the symbol counter.
// Loads write the table; encodes and flushes become queue entries.
// Depends on hbp_pkg.
module hbp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [7:0]          symbol,
    input  logic [5:0]          code_length,
    input  logic [31:0]         code_bits,
    output logic                push,
    output hbp_pkg::hbp_entry_t push_entry,
    input  logic                fifo_full
);
    import hbp_pkg::*;

    logic [ENTRY_W-1:0]   code_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] tbl_valid_reg;

    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    op_t                  s1_op_reg;
    logic                 s1_hit_reg;
    logic [COUNT_W-1:0]   s1_count_reg;
    logic [ENTRY_W-1:0]   s1_data_reg;

    logic                 accept;
    logic                 is_load;
    logic                 is_encode;
    logic                 is_flush;
    logic                 in_range;
    logic [SYM_IDX_W-1:0] idx;
    logic [LEN_W-1:0]     len_clamped;
    logic [CODE_W-1:0]    bits_masked;
    logic [COUNT_W-1:0]   count_inc;

    // A held stage-one entry blocks new items only while the queue is full.
    assign in_stall = s1_valid_reg && fifo_full;
    assign push     = s1_valid_reg && !fifo_full;

    always_comb
    begin
        accept      = in_valid && !in_stall;
        is_load     = (mode == MODE_LOAD);
        is_encode   = (mode == MODE_ENCODE);
        is_flush    = (mode == MODE_FLUSH);
        in_range    = ({1'b0, symbol} < 9'(NUM_SYMBOLS));
        idx         = symbol[SYM_IDX_W-1:0];
        len_clamped = (code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length;
        bits_masked = code_bits & CODE_W'((33'd1 << len_clamped) - 33'd1);
        count_inc   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

        count_next = count_reg;
        if (accept && is_encode)
        begin
            count_next = count_inc;
        end
        else if (accept && is_flush)
        begin
            count_next = '0;
        end

        s1_valid_next = s1_valid_reg && !push;
        if (accept && (is_encode || is_flush))
        begin
            s1_valid_next = 1'b1;
        end

        push_entry.op    = s1_op_reg;
        push_entry.clen  = s1_hit_reg ? s1_data_reg[ENTRY_W-1:CODE_W] : '0;
        push_entry.cbits = s1_hit_reg ? s1_data_reg[CODE_W-1:0] : '0;
        push_entry.count = s1_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            tbl_valid_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
            if (accept && is_load && in_range)
            begin
                tbl_valid_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_load && in_range)
        begin
            code_mem[idx] <= {len_clamped, bits_masked};
        end
        if (accept && is_encode)
        begin
            s1_data_reg <= code_mem[idx];
        end
        if (accept && (is_encode || is_flush))
        begin
            s1_op_reg    <= is_flush ? OP_FLUSH : OP_ENCODE;
            s1_hit_reg   <= is_encode && in_range && tbl_valid_reg[idx];
            s1_count_reg <= is_encode ? count_inc : count_reg;
        end
    end

endmodule

// ===== hw/rtl/hbp_back.sv =====
// Back end: appends code bits to the pending store and emits bytes one a cycle
// while out_stall allows. Takes entries from the queue; its output register
// decouples the receiver. Depends on hbp_pkg.
module hbp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  hbp_pkg::hbp_entry_t head_entry,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          packed_byte,
    output logic                last,
    output logic [31:0]         symbol_count
);
    import hbp_pkg::*;

    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [PCNT_W-1:0]  pcnt_reg;
    logic [PCNT_W-1:0]  pcnt_next;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic               last_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic               emit;
    logic [LEN_W-1:0]   total;

    assign out_valid    = out_valid_reg;
    assign packed_byte  = byte_reg;
    assign last         = last_reg;
    assign symbol_count = count_out_reg;

    always_comb
    begin
        pop   = !empty && (rem_reg == '0);
        emit  = (rem_reg != '0) && (!out_valid_reg || !out_stall);
        total = LEN_W'(pcnt_reg) + head_entry.clen;

        acc_next  = acc_reg;
        pcnt_next = pcnt_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;

        if (pop)
        begin
            cnt_next = head_entry.count;
            unique case (head_entry.op)
                OP_ENCODE:
                begin
                    // Bits above the pending count are always zero, so OR is enough.
                    acc_next  = acc_reg | (ACC_W'(head_entry.cbits) << pcnt_reg);
                    rem_next  = REM_W'(total >> 3);
                    pcnt_next = total[PCNT_W-1:0];
                end
                OP_FLUSH:
                begin
                    rem_next  = (pcnt_reg != '0) ? REM_W'(1) : '0;
                    pcnt_next = '0;
                end
                default:
                begin
                    rem_next = rem_reg;
                end
            endcase
        end
        else if (emit)
        begin
            acc_next = acc_reg >> BYTE_W;
            rem_next = rem_reg - 1'b1;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pcnt_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pcnt_reg      <= pcnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        if (emit)
        begin
            byte_reg      <= acc_reg[BYTE_W-1:0];
            last_reg      <= (rem_reg == REM_W'(1));
            count_out_reg <= cnt_reg;
        end
    end

endmodule

// ===== hw/rtl/huffman_bit_packer_top.sv =====
// Huffman bit packer top level: front end, work queue and byte packer.
// Depends on hbp_pkg, hbp_front, hbp_fifo and hbp_back.
//
// Input channel (in_valid / in_stall) takes one item per cycle. Mode 0 writes
// a code table entry, mode 1 encodes a byte, mode 2 flushes the stream, and
// mode 3 is dropped. Output channel (out_valid / out_stall) carries the packed
// bytes, with last marking the final byte of its input item and
// symbol_count the running count of encoded symbols.
// The first byte of an encode passes the front stage register, the queue,
// the packer's pending store and the output register. The input takes one
// item per cycle while the four-entry queue has room; the packer takes a new
// entry only after emitting every byte of the last, and it emits those at one
// byte a cycle while the receiver does not stall.
// Reset clears the table valid bits (all codes length zero), the pending bits,
// the counter and the queue at once. While the receiver stalls, the output
// register holds its byte, the packer and then the queue fill, and in_stall
// rises only when the queue and the front stage are both full.
module huffman_bit_packer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  symbol,
    input  logic [5:0]  code_length,
    input  logic [31:0] code_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  packed_byte,
    output logic        last,
    output logic [31:0] symbol_count
);
    import hbp_pkg::*;

    hbp_entry_t push_entry;
    hbp_entry_t head_entry;
    logic       push;
    logic       pop;
    logic       fifo_full;
    logic       fifo_empty;

    hbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .symbol      (symbol),
        .code_length (code_length),
        .code_bits   (code_bits),
        .push        (push),
        .push_entry  (push_entry),
        .fifo_full   (fifo_full)
    );

    hbp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .full       (fifo_full),
        .empty      (fifo_empty)
    );

    hbp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_entry   (head_entry),
        .empty        (fifo_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .packed_byte  (packed_byte),
        .last         (last),
        .symbol_count (symbol_count)
    );

endmodule

// ===== tb/tb_huffman_bit_packer_top.sv =====
// Self-checking testbench for huffman_bit_packer_top: table loads, encodes, flushes
// and ignored modes, with random idling on both channels, checked against a predictor.
// Depends on hbp_pkg and the huffman_bit_packer_top RTL.
`timescale 1ns / 1ps

module tb_huffman_bit_packer_top;
    import hbp_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 84;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 60000;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } code_entry_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic [COUNT_W-1:0] count;
    } packed_out_t;

    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  symbol;
        logic [5:0]  len;
        logic [31:0] bits;
        bit          typed;
        int          n_out;
        logic [31:0] out_bytes;
        logic [31:0] count;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_LOAD;
    logic [7:0]  symbol = '0;
    logic [5:0]  code_length = '0;
    logic [31:0] code_bits = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  packed_byte;
    logic        last;
    logic [31:0] symbol_count;

    // Predictor state.
    code_entry_t        code_book [NUM_SYMBOLS];
    logic [PEND_W-1:0]  carry_bits = '0;
    logic [PCNT_W-1:0]  carry_cnt = '0;
    logic [COUNT_W-1:0] seen = '0;

    packed_out_t expected_bytes [$];
    stim_row_t   directed [$];
    logic [7:0]  loaded_syms [$];

    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 32;
    int recv_idle_pct = 49;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    huffman_bit_packer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .symbol       (symbol),
        .code_length  (code_length),
        .code_bits    (code_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .packed_byte  (packed_byte),
        .last         (last),
        .symbol_count (symbol_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic expect_byte(input logic [7:0] data, input logic is_last,
                               input logic [31:0] count);
        packed_out_t entry;
        entry.data  = data;
        entry.last  = is_last;
        entry.count = count;
        expected_bytes.push_back(entry);
    endtask

    // Applies one accepted item to the predicted state; queues its bytes when asked.
    task automatic huffman_pack(input logic [1:0] m, input logic [7:0] s,
                                input logic [5:0] l, input logic [31:0] b,
                                input bit push_results);
        logic [LEN_W-1:0]  clen;
        logic [CODE_W-1:0] mask;
        logic [ACC_W-1:0]  acc;
        int total;
        int nbytes;
        case (m)
            MODE_LOAD:
            begin
                if (s < NUM_SYMBOLS)
                begin
                    clen = (l > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : l;
                    mask = 32'((33'd1 << clen) - 33'd1);
                    code_book[s].len  = clen;
                    code_book[s].bits = b & mask;
                end
            end
            MODE_ENCODE:
            begin
                clen = '0;
                acc  = '0;
                if (s < NUM_SYMBOLS)
                begin
                    clen = code_book[s].len;
                    acc  = ACC_W'(code_book[s].bits) << carry_cnt;
                end
                if (seen != COUNT_MAX)
                    seen = seen + 1;
                acc    = acc | ACC_W'(carry_bits);
                total  = carry_cnt + clen;
                nbytes = total / 8;
                for (int k = 0; k < nbytes; k++)
                begin
                    if (push_results)
                        expect_byte(acc[7:0], k == nbytes - 1, seen);
                    acc = acc >> 8;
                end
                carry_cnt  = PCNT_W'(total);
                carry_bits = acc[PEND_W-1:0] & PEND_W'((8'd1 << carry_cnt) - 8'd1);
            end
            MODE_FLUSH:
            begin
                if (carry_cnt != 0 && push_results)
                    expect_byte(BYTE_W'(carry_bits), 1'b1, seen);
                carry_bits = '0;
                carry_cnt  = '0;
                seen       = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Offers one item after a random gap and returns at the edge that takes it.
    task automatic send_item(input logic [1:0] m, input logic [7:0] s,
                             input logic [5:0] l, input logic [31:0] b,
                             input bit use_model);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        symbol      <= s;
        code_length <= l;
        code_bits   <= b;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        huffman_pack(m, s, l, b, use_model);
    endtask

    task automatic add_row(input logic [1:0] m, input logic [7:0] s, input logic [5:0] l,
                           input logic [31:0] b, input bit typed, input int n_out,
                           input logic [31:0] out_bytes, input logic [31:0] count);
        stim_row_t r;
        r.mode      = m;
        r.symbol    = s;
        r.len       = l;
        r.bits      = b;
        r.typed     = typed;
        r.n_out     = n_out;
        r.out_bytes = out_bytes;
        r.count     = count;
        directed.push_back(r);
    endtask

    task automatic check_output();
        packed_out_t want;
        if (expected_bytes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected byte %h", packed_byte));
            return;
        end
        want = expected_bytes.pop_front();
        if (packed_byte !== want.data)
            report_mismatch($sformatf("packed_byte %h, wanted %h", packed_byte, want.data));
        if (last !== want.last)
            report_mismatch($sformatf("last %b, wanted %b", last, want.last));
        if (symbol_count !== want.count)
            report_mismatch($sformatf("symbol_count %0d, wanted %0d",
                                      symbol_count, want.count));
    endtask

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_output();
    end

    // Receiver: random stall, plus one long hold-off so the queue backs up to the input.
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [1:0]  m;
        logic [7:0]  s;
        logic [5:0]  l;
        logic [31:0] b;
        int pick;
        int sent;

        foreach (code_book[i])
            code_book[i] = '0;

        // Empty table, empty flush, masked code bits, a full 32-bit code, a clamped
        // overlong length, a zero-length entry, the unused mode, then mixed packing.
        add_row(MODE_ENCODE, 8'd5,   6'd0,  32'h0,        1'b1, 0, 32'h0,        32'd0);
        add_row(MODE_FLUSH,  8'd0,   6'd0,  32'h0,        1'b1, 0, 32'h0,        32'd0);
        add_row(MODE_LOAD,   8'd0,   6'd8,  32'hFFFF_FFA5, 1'b1, 0, 32'h0,       32'd0);
        add_row(MODE_ENCODE, 8'd0,   6'd0,  32'h0,        1'b1, 1, 32'hA5,       32'd1);
        add_row(MODE_LOAD,   8'd255, 6'd32, 32'hFFFF_FFFF, 1'b1, 0, 32'h0,       32'd0);
        add_row(MODE_ENCODE, 8'd255, 6'd0,  32'h0,        1'b1, 4, 32'hFFFF_FFFF, 32'd2);
        add_row(MODE_LOAD,   8'd1,   6'd3,  32'hFFFF_FFFD, 1'b1, 0, 32'h0,       32'd0);
        add_row(MODE_ENCODE, 8'd1,   6'd0,  32'h0,        1'b1, 0, 32'h0,        32'd3);
        add_row(MODE_FLUSH,  8'd0,   6'd0,  32'h0,        1'b1, 1, 32'h05,       32'd3);
        add_row(MODE_LOAD,   8'd128, 6'd63, 32'h8000_0001, 1'b1, 0, 32'h0,       32'd0);
        add_row(MODE_ENCODE, 8'd128, 6'd0,  32'h0,        1'b1, 4, 32'h8000_0001, 32'd1);
        add_row(MODE_LOAD,   8'd3,   6'd0,  32'hFFFF_FFFF, 1'b1, 0, 32'h0,       32'd0);
        add_row(MODE_ENCODE, 8'd3,   6'd0,  32'h0,        1'b1, 0, 32'h0,        32'd2);
        add_row(MODE_UNUSED, 8'd255, 6'd63, 32'hFFFF_FFFF, 1'b1, 0, 32'h0,       32'd0);
        add_row(MODE_LOAD,   8'd2,   6'd1,  32'h0000_0001, 1'b0, 0, 32'h0,       32'd0);
        add_row(MODE_LOAD,   8'd4,   6'd33, 32'h1234_5678, 1'b0, 0, 32'h0,       32'd0);
        add_row(MODE_LOAD,   8'd6,   6'd16, 32'h0,        1'b0, 0, 32'h0,        32'd0);
        add_row(MODE_LOAD,   8'd7,   6'd7,  32'h0000_002A, 1'b0, 0, 32'h0,       32'd0);
        add_row(MODE_ENCODE, 8'd2,   6'd63, 32'hFFFF_FFFF, 1'b0, 0, 32'h0,       32'd0);
        add_row(MODE_ENCODE, 8'd4,   6'd0,  32'h0,        1'b0, 0, 32'h0,        32'd0);
        add_row(MODE_ENCODE, 8'd7,   6'd0,  32'h0,        1'b0, 0, 32'h0,        32'd0);
        add_row(MODE_ENCODE, 8'd6,   6'd0,  32'h0,        1'b0, 0, 32'h0,        32'd0);
        add_row(MODE_ENCODE, 8'd1,   6'd0,  32'h0,        1'b0, 0, 32'h0,        32'd0);
        add_row(MODE_FLUSH,  8'd0,   6'd0,  32'h0,        1'b0, 0, 32'h0,        32'd0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_item(directed[i].mode, directed[i].symbol, directed[i].len,
                      directed[i].bits, !directed[i].typed);
            if (directed[i].typed)
            begin
                for (int k = 0; k < directed[i].n_out; k++)
                    expect_byte(directed[i].out_bytes[8*k +: 8], k == directed[i].n_out - 1,
                                directed[i].count);
            end
            if (directed[i].mode == MODE_LOAD)
                loaded_syms.push_back(directed[i].symbol);
        end

        // Mostly encodes of loaded symbols, with table reloads, flushes and some noise.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == RANDOM_ITEMS / 3)
            begin
                send_idle_pct <= 49;
                recv_idle_pct <= 32;
            end
            if (sent == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
                hold_req <= 1'b1;
            end
            pick = $urandom_range(99);
            m = MODE_UNUSED;
            s = 8'($urandom_range(255));
            l = 6'($urandom_range(63));
            b = $urandom;
            if (pick < 12)
            begin
                m = MODE_LOAD;
                pick = $urandom_range(9);
                if (pick == 0)
                    l = '0;
                else if (pick == 1)
                    l = 6'($urandom_range(63, 33));
                else
                    l = 6'($urandom_range(32, 1));
            end
            else if (pick < 82)
            begin
                m = MODE_ENCODE;
                if (loaded_syms.size() > 0 && $urandom_range(9) > 0)
                    s = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
            end
            else if (pick < 95)
            begin
                m = MODE_FLUSH;
            end
            send_item(m, s, l, b, 1'b1);
            if (m == MODE_LOAD)
                loaded_syms.push_back(s);
            if (m != MODE_UNUSED)
                sent++;
        end
        in_valid <= 1'b0;

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
